@@ rtl/packed_array_with_compacting_remove_unit_defines.svh @@
// ============================================================================
// Assertion macros for the packed array unit
// Shared concurrent assertion forms, clocked on i_clk and muted in reset.
// ============================================================================
`ifndef PACKED_ARRAY_WITH_COMPACTING_REMOVE_UNIT_DEFINES_SVH
`define PACKED_ARRAY_WITH_COMPACTING_REMOVE_UNIT_DEFINES_SVH

// Same-cycle implication: when ant holds, con must hold at that edge.
`define PACR_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication: when ant holds, con must hold at the following edge.
`define PACR_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

@@ rtl/pacr_pkg.sv @@
// ============================================================================
// pacr_pkg
// Types and constants shared by the packed array unit modules.
// ============================================================================
package pacr_pkg;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 6;
    localparam int WORD_W  = 32;
    localparam int ECNT_W  = 7;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // One command, last field in the lowest bits.
    typedef struct packed {
        logic signed [WORD_W-1:0] word_in;
        logic [POS_W-1:0]         position;
        logic [CMD_W-1:0]         command;
    } t_op;

    localparam int S_TDATA_W = $bits(t_op);

    // One result, last field in the lowest bits, padded to whole bytes.
    typedef struct packed {
        logic [5:0]               pad;
        logic [STAT_W-1:0]        status;
        logic                     is_empty;
        logic [ECNT_W-1:0]        element_count;
        logic signed [WORD_W-1:0] word_out;
    } t_res;

    localparam int M_TDATA_W = $bits(t_res);

endpackage

@@ rtl/pacr_front.sv @@
// ============================================================================
// pacr_front
// Input stage: takes words from the slave stream and unpacks them into
// commands for the command queue.
// ============================================================================
module pacr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pacr_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                           o_op_valid,
    input  logic                           i_op_ready,
    output pacr_pkg::t_op                  o_op
);

    logic          r_valid;
    pacr_pkg::t_op r_op;
    logic          n_valid;

    // The holding register frees up in the same cycle the queue takes it.
    assign o_s_tready = !r_valid || i_op_ready;
    assign o_op_valid = r_valid;
    assign o_op       = r_op;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_op_ready) begin
            n_valid = 1'b0;
        end
        if (i_s_tvalid && o_s_tready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_op <= pacr_pkg::t_op'(i_s_tdata);
        end
    end

endmodule

@@ rtl/pacr_fifo.sv @@
// ============================================================================
// pacr_fifo
// Two-entry command queue between the input stage and the executor.
// ============================================================================
module pacr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_ready,
    input  pacr_pkg::t_op i_data,
    output logic          o_valid,
    input  logic          i_pop,
    output pacr_pkg::t_op o_data
);

    pacr_pkg::t_op r_slot [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_fill;
    logic          push_ok;
    logic          pop_ok;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_slot[r_rp];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            if (push_ok && !pop_ok) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/pacr_back.sv @@
// ============================================================================
// pacr_back
// Executor: owns the word memory and the live count, carries out one
// command at a time and holds the result in the master-side output register.
// ============================================================================
`include "packed_array_with_compacting_remove_unit_defines.svh"

module pacr_back #(
    parameter int CAPACITY = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    output logic                           o_q_pop,
    input  pacr_pkg::t_op                  i_q,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pacr_pkg::M_TDATA_W-1:0] o_m_tdata
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = ((CW > pacr_pkg::POS_W) ? CW : pacr_pkg::POS_W) + 1;
    localparam int CNTX = (CW > pacr_pkg::ECNT_W) ? CW : pacr_pkg::ECNT_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_READ     = 3'd1;
    localparam logic [2:0] S_SHIFT_RD = 3'd2;
    localparam logic [2:0] S_SHIFT_WR = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0]                          r_state, n_state;
    logic [CW-1:0]                       r_count, n_count;
    logic [AW-1:0]                       r_idx, n_idx;
    logic signed [pacr_pkg::WORD_W-1:0]  r_res_word, n_res_word;
    logic [pacr_pkg::STAT_W-1:0]         r_res_st, n_res_st;
    logic                                r_m_valid, n_m_valid;
    pacr_pkg::t_res                      r_m_data, n_m_data;

    logic signed [pacr_pkg::WORD_W-1:0]  r_mem [CAPACITY];
    logic signed [pacr_pkg::WORD_W-1:0]  r_rd_data;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic [AW-1:0]                       mem_raddr;
    logic signed [pacr_pkg::WORD_W-1:0]  mem_wdata;

    logic [PW-1:0]                       pos_x;
    logic [PW-1:0]                       cnt_x;
    logic [PW-1:0]                       idx_x;
    logic [AW-1:0]                       pos_addr;
    logic [CNTX-1:0]                     cnt_ext;
    logic                                out_free;

    assign pos_x     = PW'(i_q.position);
    assign cnt_x     = PW'(r_count);
    assign idx_x     = PW'(r_idx);
    assign pos_addr  = pos_x[AW-1:0];
    assign cnt_ext   = CNTX'(r_count);
    assign out_free  = !r_m_valid || i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_res_word = r_res_word;
        n_res_st   = r_res_st;
        n_m_valid  = r_m_valid;
        n_m_data   = r_m_data;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = r_rd_data;
        mem_raddr  = r_idx + AW'(1);
        o_q_pop    = 1'b0;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop    = 1'b1;
                    n_res_word = '0;
                    n_res_st   = pacr_pkg::ST_OK;
                    n_state    = S_DONE;
                    if (i_q.command == pacr_pkg::CMD_APPEND) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_res_st = pacr_pkg::ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[AW-1:0];
                            mem_wdata = i_q.word_in;
                            n_count   = r_count + CW'(1);
                        end
                    end else if (pos_x >= cnt_x) begin
                        n_res_st = pacr_pkg::ST_RANGE;
                    end else begin
                        unique case (i_q.command)
                            pacr_pkg::CMD_READ: begin
                                mem_raddr = pos_addr;
                                n_state   = S_READ;
                            end
                            pacr_pkg::CMD_WRITE: begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_addr;
                                mem_wdata = i_q.word_in;
                            end
                            pacr_pkg::CMD_REMOVE: begin
                                n_idx = pos_addr;
                                if ((pos_x + PW'(1)) >= cnt_x) begin
                                    n_count = r_count - CW'(1);
                                end else begin
                                    n_state = S_SHIFT_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_READ: begin
                n_res_word = r_rd_data;
                n_state    = S_DONE;
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + AW'(1);
                if ((idx_x + PW'(2)) >= cnt_x) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_m_valid              = 1'b1;
                    n_m_data.pad           = '0;
                    n_m_data.status        = r_res_st;
                    n_m_data.is_empty      = (r_count == '0);
                    n_m_data.element_count = cnt_ext[pacr_pkg::ECNT_W-1:0];
                    n_m_data.word_out      = r_res_word;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_res_word <= n_res_word;
        r_res_st   <= n_res_st;
        r_m_data   <= n_m_data;
    end

    // Word memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    `PACR_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(CAPACITY), "live count above capacity")
    `PACR_ASSERT_NOW(a_shift_in_range, r_state == S_SHIFT_RD || r_state == S_SHIFT_WR,
        (idx_x + PW'(1)) < cnt_x, "shift source index beyond live count")
    `PACR_ASSERT_NEXT(a_count_step, r_state != S_IDLE && r_state != S_SHIFT_WR,
        r_count == $past(r_count), "live count moved outside a command step")
    `PACR_ASSERT_NOW(a_no_pop_busy, o_q_pop, r_state == S_IDLE && i_q_valid,
        "queue popped while executor busy")

endmodule

@@ rtl/packed_array_with_compacting_remove_unit.sv @@
// ============================================================================
// packed_array_with_compacting_remove_unit
// Densely packed array of signed 32-bit words with append, read, write and
// compacting remove, driven by a command stream and answered on a result
// stream.
// ============================================================================
//
//  Channel  | Dir | Signals                        | Payload
//  ---------+-----+--------------------------------+--------------------------
//  command  | in  | i_s_tvalid/o_s_tready/i_s_tdata| command, position, word_in
//  result   | out | o_m_tvalid/i_m_tready/o_m_tdata| word_out, element_count,
//           |     |                                | is_empty, status
//
// Executor steps: append, write and every refused command go from the idle
// state straight to the done state, a read passes through a read state,
// and a remove moves each later word through the single read port and then
// the single write port of the word memory.
// Reset: synchronous, active-low i_rst_n empties the array and the queues;
// the word memory itself is not cleared and needs no clearing pass.
// Stalls: a two-entry command queue sits between the input register and
// the executor, so the slave side accepts words, until both are full, while
// a remove is in progress or a finished result waits in the output register.
//
// Each input word is unpacked in the front stage and queued. The executor
// checks the command against the live count: an append to a full array is
// reported as full, and an index at or past the count is reported as out of
// range, both leaving the array untouched. A remove walks the later words
// down one place each and then drops the count. One result word is sent for
// every command word, in order.
// ============================================================================
module packed_array_with_compacting_remove_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [1:0] command, [7:2] position, [39:8] word_in
    input  logic [pacr_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] word_out, [38:32] element_count, [39] is_empty, [41:40] status,
    // [47:42] zero
    output logic [pacr_pkg::M_TDATA_W-1:0] o_m_tdata
);

    pacr_pkg::t_op front_op;
    logic          front_valid;
    logic          q_ready;
    pacr_pkg::t_op q_op;
    logic          q_valid;
    logic          q_pop;

    pacr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_op_valid (front_valid),
        .i_op_ready (q_ready),
        .o_op       (front_op)
    );

    pacr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (q_ready),
        .i_data  (front_op),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_op)
    );

    pacr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q        (q_op),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

@@ tb/sv/packed_array_with_compacting_remove_unit_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// packed_array_with_compacting_remove_unit_tb
// Self-checking bench for the packed word array. A short directed table covers
// the empty edge, out-of-range indexes and every command. A long
// random run in fill, churn and drain episodes follows and is checked word by
// word against an in-bench array predictor, with random idling on both sides.
// ============================================================================
module packed_array_with_compacting_remove_unit_tb;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1825;
    localparam int PLAN_LEN     = 25;
    localparam int MAX_REPORTS  = 40;
    localparam int SETTLE_CYC   = 16;

    // One directed step. When typed is set, the expected result is taken from
    // the row; otherwise the array predictor supplies it.
    typedef struct packed {
        logic [pacr_pkg::CMD_W-1:0]  cmd;
        logic [pacr_pkg::POS_W-1:0]  pos;
        logic [pacr_pkg::WORD_W-1:0] word;
        logic                        typed;
        logic [pacr_pkg::WORD_W-1:0] rd;
        logic [pacr_pkg::ECNT_W-1:0] cnt;
        logic                        empty;
        logic [pacr_pkg::STAT_W-1:0] st;
    } t_plan_row;

    // Random episodes: fill favors appends, drain favors removes, churn mixes.
    typedef enum logic [1:0] {EP_FILL, EP_CHURN, EP_DRAIN} t_episode;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pacr_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pacr_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the array, updated when a command word is accepted.
    logic [pacr_pkg::WORD_W-1:0] shadow_words [CAPACITY];
    int unsigned                 shadow_count = 0;

    pacr_pkg::t_res pending_results [$];
    int unsigned    mismatch_count = 0;
    int unsigned    results_seen   = 0;

    // Stretches with no idling at all come from these flags.
    bit          sender_quiet   = 1'b0;
    bit          receiver_quiet = 1'b0;
    t_episode    episode        = EP_FILL;
    int unsigned episode_left   = 90;

    t_plan_row directed_plan [PLAN_LEN] = '{
        // Commands on the empty array are all out of range.
        '{pacr_pkg::CMD_READ,   6'd0,  32'h0000_0000, 1'b1,
          32'h0, 7'd0, 1'b1, pacr_pkg::ST_RANGE},
        '{pacr_pkg::CMD_REMOVE, 6'd0,  32'h0000_0000, 1'b1,
          32'h0, 7'd0, 1'b1, pacr_pkg::ST_RANGE},
        '{pacr_pkg::CMD_WRITE,  6'd63, 32'h7FFF_FFFF, 1'b1,
          32'h0, 7'd0, 1'b1, pacr_pkg::ST_RANGE},
        // Appends of the word extremes.
        '{pacr_pkg::CMD_APPEND, 6'd0,  32'h7FFF_FFFF, 1'b1,
          32'h0, 7'd1, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_APPEND, 6'd63, 32'h8000_0000, 1'b1,
          32'h0, 7'd2, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_APPEND, 6'd0,  32'hFFFF_FFFF, 1'b1,
          32'h0, 7'd3, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_APPEND, 6'd0,  32'h0000_0000, 1'b1,
          32'h0, 7'd4, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_READ,   6'd0,  32'hFFFF_FFFF, 1'b1,
          32'h7FFF_FFFF, 7'd4, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_READ,   6'd1,  32'h0000_0000, 1'b1,
          32'h8000_0000, 7'd4, 1'b0, pacr_pkg::ST_OK},
        // The highest position and an index equal to the count.
        '{pacr_pkg::CMD_READ,   6'd63, 32'h0000_0000, 1'b1,
          32'h0, 7'd4, 1'b0, pacr_pkg::ST_RANGE},
        '{pacr_pkg::CMD_READ,   6'd4,  32'h0000_0000, 1'b1,
          32'h0, 7'd4, 1'b0, pacr_pkg::ST_RANGE},
        '{pacr_pkg::CMD_WRITE,  6'd4,  32'h1234_5678, 1'b1,
          32'h0, 7'd4, 1'b0, pacr_pkg::ST_RANGE},
        '{pacr_pkg::CMD_REMOVE, 6'd4,  32'h0000_0000, 1'b1,
          32'h0, 7'd4, 1'b0, pacr_pkg::ST_RANGE},
        // Overwrite, then removes from the middle, the end and the front.
        '{pacr_pkg::CMD_WRITE,  6'd2,  32'h5A5A_5A5A, 1'b0,
          32'h0, 7'd0, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_READ,   6'd2,  32'h0000_0000, 1'b0,
          32'h0, 7'd0, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_REMOVE, 6'd1,  32'h0000_0000, 1'b0,
          32'h0, 7'd0, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_READ,   6'd1,  32'h0000_0000, 1'b0,
          32'h0, 7'd0, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_READ,   6'd2,  32'h0000_0000, 1'b0,
          32'h0, 7'd0, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_REMOVE, 6'd2,  32'h0000_0000, 1'b0,
          32'h0, 7'd0, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_REMOVE, 6'd0,  32'h0000_0000, 1'b0,
          32'h0, 7'd0, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_READ,   6'd0,  32'h0000_0000, 1'b0,
          32'h0, 7'd0, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_REMOVE, 6'd0,  32'h0000_0000, 1'b1,
          32'h0, 7'd0, 1'b1, pacr_pkg::ST_OK},
        // A lone word appended and removed again.
        '{pacr_pkg::CMD_APPEND, 6'd63, 32'h0000_0001, 1'b1,
          32'h0, 7'd1, 1'b0, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_REMOVE, 6'd0,  32'h0000_0000, 1'b1,
          32'h0, 7'd0, 1'b1, pacr_pkg::ST_OK},
        '{pacr_pkg::CMD_READ,   6'd0,  32'h0000_0000, 1'b1,
          32'h0, 7'd0, 1'b1, pacr_pkg::ST_RANGE}
    };

    packed_array_with_compacting_remove_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // Applies one command to the shadow array and returns the result word the
    // block must send for it.
    function automatic pacr_pkg::t_res array_apply(input pacr_pkg::t_op op);
        pacr_pkg::t_res res;
        res        = '0;
        res.status = pacr_pkg::ST_OK;
        if (op.command == pacr_pkg::CMD_APPEND) begin
            if (shadow_count >= CAPACITY) begin
                res.status = pacr_pkg::ST_FULL;
            end else begin
                shadow_words[shadow_count[pacr_pkg::POS_W-1:0]] = op.word_in;
                shadow_count++;
            end
        end else if (op.position >= shadow_count) begin
            res.status = pacr_pkg::ST_RANGE;
        end else if (op.command == pacr_pkg::CMD_READ) begin
            res.word_out = shadow_words[op.position];
        end else if (op.command == pacr_pkg::CMD_WRITE) begin
            shadow_words[op.position] = op.word_in;
        end else begin
            // Compacting remove: every later word moves down one place.
            for (int k = int'(op.position); k + 1 < shadow_count; k++) begin
                shadow_words[pacr_pkg::POS_W'(k)] = shadow_words[pacr_pkg::POS_W'(k + 1)];
            end
            shadow_count--;
        end
        res.element_count = shadow_count[pacr_pkg::ECNT_W-1:0];
        res.is_empty      = (shadow_count == 0);
        return res;
    endfunction

    // Picks the next random command from the current episode. Positions mostly
    // land inside the live part of the array; the rest are anywhere.
    function automatic pacr_pkg::t_op draw_command();
        pacr_pkg::t_op op;
        int unsigned   roll;
        int unsigned   word_roll;
        if (episode_left == 0) begin
            episode      = t_episode'($urandom_range(0, 2));
            episode_left = $urandom_range(20, 120);
        end
        episode_left--;
        roll = $urandom_range(0, 99);
        case (episode)
            EP_FILL: begin
                op.command = (roll < 80) ? pacr_pkg::CMD_APPEND :
                             (roll < 87) ? pacr_pkg::CMD_READ :
                             (roll < 94) ? pacr_pkg::CMD_WRITE : pacr_pkg::CMD_REMOVE;
            end
            EP_DRAIN: begin
                op.command = (roll < 65) ? pacr_pkg::CMD_REMOVE :
                             (roll < 80) ? pacr_pkg::CMD_READ :
                             (roll < 92) ? pacr_pkg::CMD_WRITE : pacr_pkg::CMD_APPEND;
            end
            default: begin
                op.command = (roll < 25) ? pacr_pkg::CMD_APPEND :
                             (roll < 50) ? pacr_pkg::CMD_READ :
                             (roll < 75) ? pacr_pkg::CMD_WRITE : pacr_pkg::CMD_REMOVE;
            end
        endcase
        if (shadow_count > 0 && $urandom_range(0, 99) < 85) begin
            op.position = pacr_pkg::POS_W'($urandom_range(0, shadow_count - 1));
        end else begin
            op.position = pacr_pkg::POS_W'($urandom_range(0, 63));
        end
        word_roll = $urandom_range(0, 15);
        case (word_roll)
            0:       op.word_in = 32'h7FFF_FFFF;
            1:       op.word_in = 32'h8000_0000;
            2:       op.word_in = 32'h0000_0000;
            3:       op.word_in = 32'hFFFF_FFFF;
            default: op.word_in = $urandom;
        endcase
        return op;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [pacr_pkg::WORD_W-1:0] got,
                                   input logic [pacr_pkg::WORD_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] result %0d: %s got %h, expected %h",
                     $realtime, results_seen, what, got, want);
        end
    endtask

    // Offers one command word after a random gap and waits for the handshake.
    // Valid stays high across back-to-back words, so it is only lowered when a
    // gap follows. The expectation is queued at the accepting edge.
    task automatic push_op(input pacr_pkg::t_op op, input bit typed,
                           input pacr_pkg::t_res typed_res);
        int unsigned    gap;
        pacr_pkg::t_res want;
        if ($urandom_range(0, 39) == 0) sender_quiet = ~sender_quiet;
        gap = sender_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        want = array_apply(op);
        pending_results.push_back(typed ? typed_res : want);
    endtask

    // Stops sending until every outstanding result word has been taken.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Stimulus: reset, the directed table, then the random episodes.
    initial begin
        pacr_pkg::t_op  op;
        pacr_pkg::t_res row_res;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_LEN; r++) begin
            op.command            = directed_plan[r].cmd;
            op.position           = directed_plan[r].pos;
            op.word_in            = directed_plan[r].word;
            row_res               = '0;
            row_res.word_out      = directed_plan[r].rd;
            row_res.element_count = directed_plan[r].cnt;
            row_res.is_empty      = directed_plan[r].empty;
            row_res.status        = directed_plan[r].st;
            push_op(op, directed_plan[r].typed, row_res);
        end
        hold_until_drained();

        // The first episode is a fill long enough to hit the full array.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) hold_until_drained();
            op = draw_command();
            push_op(op, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        do @(posedge clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random stalls per word, then every accepted word is checked
    // field by field against the oldest expectation.
    initial begin
        int unsigned    stall;
        pacr_pkg::t_res got;
        pacr_pkg::t_res want;
        wait (rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) receiver_quiet = ~receiver_quiet;
            stall = receiver_quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got = pacr_pkg::t_res'(m_tdata);
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, word_out", got.word_out, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.word_out !== want.word_out)
                    report_mismatch("word_out", got.word_out, want.word_out);
                if (got.element_count !== want.element_count)
                    report_mismatch("element_count", 32'(got.element_count),
                                    32'(want.element_count));
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.pad !== '0)
                    report_mismatch("padding", 32'(got.pad), '0);
            end
        end
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
